@@ sv/pprd_pkg.sv @@
// Package for the pulse peak rate detector: widths, constants, microcode
// control word types and the microcode program table.
// No dependencies.
package pprd_pkg;

	localparam int PPRD_SAMPLE_BITS = 10;
	localparam int PPRD_TIME_BITS   = 32;
	localparam int THR_W            = 10;
	localparam int PEAK_W           = 10;
	localparam int BPM_W            = 16;
	localparam int STEP_W           = 3;
	localparam int DCNT_W           = 4;
	localparam int APB_AW           = 2;
	localparam int APB_DW           = 32;

	localparam logic [THR_W-1:0]  THR_RESET     = THR_W'(5);
	localparam logic [BPM_W-1:0]  MS_PER_MINUTE = BPM_W'(60000);
	localparam logic [APB_AW-1:0] ADDR_THR      = APB_AW'(0);

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t S_WAIT  = step_t'(0);
	localparam step_t S_PHASE = step_t'(1);
	localparam step_t S_TEST  = step_t'(2);
	localparam step_t S_MEAN  = step_t'(3);
	localparam step_t S_GAP   = step_t'(4);
	localparam step_t S_DIV   = step_t'(5);
	localparam step_t S_EMIT  = step_t'(6);

	typedef enum logic [2:0] {
		OP_WAIT,
		OP_PHASE,
		OP_TEST,
		OP_MEAN,
		OP_GAP,
		OP_DIV,
		OP_EMIT
	} op_t;

	typedef enum logic [1:0] {
		COND_ALWAYS,
		COND_ACCEPT,
		COND_DIV_LAST,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t pass;
		step_t fail;
	} ctrl_t;

	typedef struct packed {
		logic accept;
		logic div_last;
		logic out_free;
	} stat_t;

	function automatic ctrl_t pprd_ucode(input step_t step);
		ctrl_t cw;
		case (step)
			S_WAIT:  cw = '{op: OP_WAIT,  cond: COND_ACCEPT,   pass: S_PHASE, fail: S_WAIT};
			S_PHASE: cw = '{op: OP_PHASE, cond: COND_ALWAYS,   pass: S_TEST,  fail: S_TEST};
			S_TEST:  cw = '{op: OP_TEST,  cond: COND_ALWAYS,   pass: S_MEAN,  fail: S_MEAN};
			S_MEAN:  cw = '{op: OP_MEAN,  cond: COND_ALWAYS,   pass: S_GAP,   fail: S_GAP};
			S_GAP:   cw = '{op: OP_GAP,   cond: COND_ALWAYS,   pass: S_DIV,   fail: S_DIV};
			S_DIV:   cw = '{op: OP_DIV,   cond: COND_DIV_LAST, pass: S_EMIT,  fail: S_DIV};
			S_EMIT:  cw = '{op: OP_EMIT,  cond: COND_OUT_FREE, pass: S_WAIT,  fail: S_EMIT};
			default: cw = '{op: OP_WAIT,  cond: COND_ALWAYS,   pass: S_WAIT,  fail: S_WAIT};
		endcase
		return cw;
	endfunction

endpackage

@@ sv/pprd_if.sv @@
// Request channels of the pulse peak rate detector: sample in, result out.
// Depends on pprd_pkg.
interface pprd_in_if import pprd_pkg::*; #(
	parameter int SAMPLE_BITS = PPRD_SAMPLE_BITS
) ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface pprd_out_if import pprd_pkg::*; #(
	parameter int TIME_BITS = PPRD_TIME_BITS
) ();
	logic                 valid;
	logic                 ready;
	logic                 peak_detected;
	logic [PEAK_W-1:0]    peak_value;
	logic                 time_stored;
	logic [TIME_BITS-1:0] beat_gap;
	logic                 rate_valid;
	logic [BPM_W-1:0]     beats_per_minute;

	modport source (output valid, output peak_detected, output peak_value,
		output time_stored, output beat_gap, output rate_valid,
		output beats_per_minute, input ready);
	modport sink   (input valid, input peak_detected, input peak_value,
		input time_stored, input beat_gap, input rate_valid,
		input beats_per_minute, output ready);
endinterface

@@ sv/pprd_seq.sv @@
// Microcode sequencer: step counter, program table lookup, conditional jumps.
// Depends on pprd_pkg.
module pprd_seq import pprd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  stat_t stat,
	output ctrl_t ctrl
);

	step_t step_q;
	logic  cond_ok;

	assign ctrl = pprd_ucode(step_q);

	always_comb begin
		case (ctrl.cond)
			COND_ALWAYS:   cond_ok = 1'b1;
			COND_ACCEPT:   cond_ok = stat.accept;
			COND_DIV_LAST: cond_ok = stat.div_last;
			COND_OUT_FREE: cond_ok = stat.out_free;
			default:       cond_ok = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_WAIT;
		end else begin
			step_q <= cond_ok ? ctrl.pass : ctrl.fail;
		end
	end

endmodule

@@ sv/pprd_dp.sv @@
// Datapath: slope tracking, peak and time rings, gap, bit-serial divider,
// output register. Driven by the sequencer control word.
// Depends on pprd_pkg and pprd_if.
module pprd_dp import pprd_pkg::*; #(
	parameter int SAMPLE_BITS = PPRD_SAMPLE_BITS,
	parameter int TIME_BITS   = PPRD_TIME_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctrl_t             ctrl,
	output stat_t             stat,
	input  logic [THR_W-1:0]  thr,
	pprd_in_if.sink           in_ch,
	pprd_out_if.source        out_ch
);

	localparam int DW  = SAMPLE_BITS + 1;
	localparam int CW  = ((DW > THR_W + 1) ? DW : THR_W + 1) + 1;
	localparam int RW  = BPM_W + 1;
	localparam int GW  = ((TIME_BITS > RW) ? TIME_BITS : RW) + 1;

	logic                    phase_q;
	logic [TIME_BITS-1:0]    tick_q;
	logic [SAMPLE_BITS-1:0]  prev_q;
	logic signed [DW-1:0]    diff_q;
	logic                    rising_q;
	logic [SAMPLE_BITS-1:0]  amp_q [2];
	logic                    aslot_q;
	logic [TIME_BITS-1:0]    time_q [2];
	logic                    tslot_q;
	logic                    got_peak_q;
	logic                    stored_q;
	logic [SAMPLE_BITS-1:0]  cur_q;
	logic [TIME_BITS-1:0]    gap_q;
	logic [BPM_W-1:0]        rem_q;
	logic [BPM_W-1:0]        quo_q;
	logic [DCNT_W-1:0]       cnt_q;
	logic                    oval_q;
	logic                    o_peak_q;
	logic [PEAK_W-1:0]       o_pval_q;
	logic                    o_stored_q;
	logic [TIME_BITS-1:0]    o_gap_q;
	logic                    o_rv_q;
	logic [BPM_W-1:0]        o_bpm_q;

	logic signed [DW-1:0]    diff_new;
	logic signed [CW-1:0]    diff_x;
	logic signed [CW-1:0]    thr_x;
	logic                    rise_c;
	logic                    peak_c;
	logic [SAMPLE_BITS:0]    amp_sum;
	logic [SAMPLE_BITS-1:0]  mean;
	logic [TIME_BITS-1:0]    gap_c;
	logic [RW-1:0]           trial;
	logic [GW-1:0]           trial_sub;
	logic                    trial_ge;
	logic                    accept;
	logic                    out_free;
	logic                    load;

	assign accept   = in_ch.valid && in_ch.ready;
	assign out_free = !oval_q || out_ch.ready;
	assign load     = (ctrl.op == OP_EMIT) && out_free;

	assign in_ch.ready = (ctrl.op == OP_WAIT);
	assign stat = '{accept: accept, div_last: (cnt_q == '1), out_free: out_free};

	always_comb begin
		diff_new  = $signed({1'b0, prev_q}) - $signed({1'b0, cur_q});
		diff_x    = CW'(diff_q);
		thr_x     = $signed(CW'(thr));
		rise_c    = rising_q || (diff_x < -thr_x);
		peak_c    = rise_c && !diff_q[DW-1] && (diff_q != '0);
		amp_sum   = {1'b0, amp_q[0]} + {1'b0, amp_q[1]};
		mean      = amp_sum[SAMPLE_BITS:1];
		gap_c     = (time_q[0] > time_q[1]) ? (time_q[0] - time_q[1])
		                                    : (time_q[1] - time_q[0]);
		trial     = {rem_q, MS_PER_MINUTE[~cnt_q]};
		trial_sub = GW'(trial) - GW'(gap_q);
		trial_ge  = GW'(trial) >= GW'(gap_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= 1'b1;
			tick_q     <= '0;
			prev_q     <= '0;
			diff_q     <= '0;
			rising_q   <= 1'b0;
			amp_q[0]   <= '0;
			amp_q[1]   <= '0;
			aslot_q    <= 1'b0;
			time_q[0]  <= '0;
			time_q[1]  <= '0;
			tslot_q    <= 1'b0;
			got_peak_q <= 1'b0;
			stored_q   <= 1'b0;
		end else begin
			case (ctrl.op)
				OP_PHASE: begin
					phase_q <= ~phase_q;
					tick_q  <= tick_q + 1'b1;
					if (!phase_q) begin
						prev_q <= cur_q;
					end else begin
						diff_q <= diff_new;
					end
				end
				OP_TEST: begin
					if (peak_c) begin
						rising_q       <= 1'b0;
						got_peak_q     <= 1'b1;
						amp_q[aslot_q] <= cur_q;
						aslot_q        <= ~aslot_q;
					end else begin
						rising_q   <= rise_c;
						got_peak_q <= 1'b0;
					end
				end
				OP_MEAN: begin
					if (got_peak_q && (cur_q > mean)) begin
						stored_q        <= 1'b1;
						time_q[tslot_q] <= tick_q;
						tslot_q         <= ~tslot_q;
					end else begin
						stored_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= in_ch.sample;
		end
		case (ctrl.op)
			OP_GAP: begin
				gap_q <= gap_c;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
			end
			OP_DIV: begin
				rem_q <= trial_ge ? BPM_W'(trial_sub) : BPM_W'(trial);
				quo_q <= {quo_q[BPM_W-2:0], trial_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (load) begin
			o_peak_q   <= got_peak_q;
			o_pval_q   <= got_peak_q ? PEAK_W'(cur_q) : '0;
			o_stored_q <= stored_q;
			o_gap_q    <= gap_q;
			o_rv_q     <= (gap_q != '0);
			o_bpm_q    <= (gap_q != '0) ? quo_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
		end else if (load) begin
			oval_q <= 1'b1;
		end else if (out_ch.ready) begin
			oval_q <= 1'b0;
		end
	end

	assign out_ch.valid            = oval_q;
	assign out_ch.peak_detected    = o_peak_q;
	assign out_ch.peak_value       = o_pval_q;
	assign out_ch.time_stored      = o_stored_q;
	assign out_ch.beat_gap         = o_gap_q;
	assign out_ch.rate_valid       = o_rv_q;
	assign out_ch.beats_per_minute = o_bpm_q;

endmodule

@@ sv/pulse_peak_rate_detector_top.sv @@
// Top level of the pulse peak rate detector: APB threshold register,
// microcode sequencer and datapath. Depends on pprd_pkg, pprd_if,
// pprd_seq and pprd_dp.
//
//   channel  dir  handshake        payload
//   in_ch    in   valid / ready    sample
//   out_ch   out  valid / ready    peak_detected, peak_value, time_stored,
//                                  beat_gap, rate_valid, beats_per_minute
//   apb      in   psel / penable   paddr, pwdata, prdata (rise_threshold at 0)
//
// Each sample runs through accept, four update steps, a 16-step
// restoring divider for 60000 / gap, and one output load.
// in_ch.ready is high only while waiting, so a new sample waits for the load.
// A full output register holds the sequencer at the load step until taken.
// Reset is asynchronous and at once clears all but the sample, divider and output data registers; no clearing pass.
module pulse_peak_rate_detector_top import pprd_pkg::*; #(
	parameter int SAMPLE_BITS = PPRD_SAMPLE_BITS,
	parameter int TIME_BITS   = PPRD_TIME_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	pprd_in_if.sink           in_ch,
	pprd_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [THR_W-1:0] thr_q;
	ctrl_t            ctrl;
	stat_t            stat;
	logic             cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_THR);
	assign prdata = (paddr == ADDR_THR) ? APB_DW'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	pprd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	pprd_dp #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.stat   (stat),
		.thr    (thr_q),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("request accepted while previous one in flight");

	a_no_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.peak_detected) |->
		(out_ch.peak_value == '0 && !out_ch.time_stored))
		else $error("peak fields set without a peak");

	a_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.rate_valid == (out_ch.beat_gap != '0)) &&
		(out_ch.rate_valid || out_ch.beats_per_minute == '0))
		else $error("rate inconsistent with gap");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (thr_q == $past(pwdata[THR_W-1:0])))
		else $error("threshold write lost");

endmodule
